FILE: rtl/core/response_token_matcher_core_defines.svh
// assertion macros for the response token matcher core
// used by files that include this header; expects clk and rst_n in scope
`ifndef RESPONSE_TOKEN_MATCHER_CORE_DEFINES_SVH
`define RESPONSE_TOKEN_MATCHER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RTM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RTM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rtm_pkg.sv
// shared types, codes and constants for the response token matcher
// no dependencies
`default_nettype none

package rtm_pkg;

    localparam int BUFFER_BYTES_DEF = 512;
    localparam int PATTERN_MAX      = 8;
    localparam int COUNT_W          = 9;

    typedef logic [1:0] cmd_t;
    typedef logic [1:0] status_t;
    typedef logic [1:0] cfg_idx_t;

    localparam cmd_t CMD_START = 2'd0;
    localparam cmd_t CMD_BYTE  = 2'd1;
    localparam cmd_t CMD_TICK  = 2'd2;

    localparam status_t ST_PENDING = 2'd0;
    localparam status_t ST_FOUND   = 2'd1;
    localparam status_t ST_ERROR   = 2'd2;
    localparam status_t ST_TIMEOUT = 2'd3;

    localparam cfg_idx_t CFG_PATTERN = 2'd0;
    localparam cfg_idx_t CFG_LENGTH  = 2'd1;
    localparam cfg_idx_t CFG_TIMEOUT = 2'd2;

    // "ERROR" with the first character in the low byte
    localparam logic [39:0] ERR_TOKEN = 40'h524F525245;

    localparam logic [63:0] PATTERN_RST = 64'h0000_0000_0000_4B4F;
    localparam logic [3:0]  LENGTH_RST  = 4'd2;
    localparam logic [15:0] TIMEOUT_RST = 16'd2000;

    typedef struct packed {
        logic [63:0] pattern;
        logic [3:0]  eff_len;
        logic [15:0] timeout;
    } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/response_token_matcher_core.sv
// a request accepted into the input register moves on into the result register
// throughput: one request per cycle while out_stall is low; the input register hands to the result
// register whenever that register is empty or being taken
// reset: asynchronous active-low rst_n clears both stages, the wait state
// (pending, empty buffer) and loads default configuration ("OK", 2, 2000)
// depends on rtm_pkg, rtm_cfg, rtm_match, response_token_matcher_core_defines.svh
`default_nettype none

`include "response_token_matcher_core_defines.svh"

module response_token_matcher_core #(
    parameter int BUFFER_BYTES = rtm_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire rtm_pkg::cmd_t              command,
    input  wire logic [7:0]                 rx_byte,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output rtm_pkg::status_t                status,
    output logic [rtm_pkg::COUNT_W-1:0]     stored_count,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire rtm_pkg::cfg_idx_t          cfg_index,
    input  wire logic [63:0]                cfg_data
);
    import rtm_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_BYTES);

    cfg_t cfg;

    logic             s1_valid_reg, s1_valid_next;
    cmd_t             s1_cmd_reg;
    logic [7:0]       s1_byte_reg;
    logic             out_valid_reg, out_valid_next;
    status_t          status_reg;
    logic [COUNT_W-1:0] count_reg;

    logic             in_acc;
    logic             s1_adv;
    status_t          status_calc;
    logic [CNT_W-1:0] count_calc;

    rtm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rtm_match #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_match (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_adv),
        .cmd         (s1_cmd_reg),
        .rx_byte     (s1_byte_reg),
        .cfg         (cfg),
        .status_next (status_calc),
        .count_next  (count_calc)
    );

    // input stage moves on when the result register is free or being taken
    assign s1_adv   = s1_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall = s1_valid_reg & ~s1_adv;
    assign in_acc   = in_valid & ~in_stall;

    assign s1_valid_next  = in_acc | (s1_valid_reg & ~s1_adv);
    assign out_valid_next = s1_adv | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_cmd_reg  <= command;
            s1_byte_reg <= rx_byte;
        end
        if (s1_adv)
        begin
            status_reg <= status_calc;
            count_reg  <= COUNT_W'(count_calc);
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign stored_count = count_reg;

    `RTM_ASSERT_IMP(a_stall_needs_item, in_stall, s1_valid_reg, "input stalled with empty stage")
    `RTM_ASSERT_NXT(a_adv_gives_result, s1_adv, out_valid_reg, "advanced request lost its result")
    `RTM_ASSERT_NXT(a_start_clears_count, s1_adv && (s1_cmd_reg == CMD_START),
                    count_reg == '0, "start request reported nonzero count")

endmodule

`default_nettype wire

FILE: rtl/core/rtm_cfg.sv
// configuration registers and the effective token length derived from them
// depends on rtm_pkg
`default_nettype none

module rtm_cfg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire rtm_pkg::cfg_idx_t cfg_index,
    input  wire logic [63:0]       cfg_data,
    output rtm_pkg::cfg_t          cfg
);
    import rtm_pkg::*;

    localparam logic [3:0] LEN_MAX = (PATTERN_MAX < 8) ? 4'(PATTERN_MAX) : 4'd8;

    logic [63:0] pattern_reg, pattern_next;
    logic [3:0]  length_reg, length_next;
    logic [15:0] timeout_reg, timeout_next;
    logic [3:0]  eff_len_reg, eff_len_next;
    logic [3:0]  len_clamp;
    logic        wr;

    assign cfg_ready = 1'b1;
    assign wr = cfg_valid & cfg_ready;

    always_comb
    begin
        pattern_next = pattern_reg;
        length_next  = length_reg;
        timeout_next = timeout_reg;
        if (wr)
        begin
            unique case (cfg_index)
                CFG_PATTERN: pattern_next = cfg_data;
                CFG_LENGTH:  length_next  = cfg_data[3:0];
                CFG_TIMEOUT: timeout_next = cfg_data[15:0];
                default:     ;
            endcase
        end
    end

    // clamp, then cut at the first zero byte inside the token
    always_comb
    begin
        len_clamp = (length_next > LEN_MAX) ? LEN_MAX : length_next;
        eff_len_next = len_clamp;
        for (int i = 7; i >= 0; i--)
        begin
            if ((4'(i) < len_clamp) && (pattern_next[8*i +: 8] == 8'd0))
                eff_len_next = 4'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= PATTERN_RST;
            length_reg  <= LENGTH_RST;
            timeout_reg <= TIMEOUT_RST;
            eff_len_reg <= LENGTH_RST;
        end
        else
        begin
            pattern_reg <= pattern_next;
            length_reg  <= length_next;
            timeout_reg <= timeout_next;
            eff_len_reg <= eff_len_next;
        end
    end

    assign cfg.pattern = pattern_reg;
    assign cfg.eff_len = eff_len_reg;
    assign cfg.timeout = timeout_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rtm_match.sv
// wait state and per-request update: window compare, byte count, idle timeout
// depends on rtm_pkg
`default_nettype none

module rtm_match #(
    parameter int BUFFER_BYTES = rtm_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire rtm_pkg::cmd_t               cmd,
    input  wire logic [7:0]                  rx_byte,
    input  wire rtm_pkg::cfg_t               cfg,
    output rtm_pkg::status_t                 status_next,
    output logic [$clog2(BUFFER_BYTES)-1:0]  count_next
);
    import rtm_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_BYTES);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUFFER_BYTES - 1);

    logic [63:0]      window_reg, window_next;
    logic [CNT_W-1:0] count_reg;
    logic             zero_reg, zero_next;
    logic [15:0]      idle_reg, idle_next;
    status_t          outcome_reg, outcome_next;

    logic             timed;
    logic             stored;
    logic [63:0]      shifted;
    logic [5:0]       sh_bits;
    logic [63:0]      win_top;
    logic [63:0]      pat_mask;
    logic             exp_hit;
    logic             err_hit;

    assign timed   = (outcome_reg == ST_PENDING) && (idle_reg >= cfg.timeout);
    assign stored  = count_reg < CNT_LIMIT;
    assign shifted = {rx_byte, window_reg[63:8]};

    // newest eff_len bytes against the token; valid for lengths 1..8
    assign sh_bits  = {3'(4'd8 - cfg.eff_len), 3'b000};
    assign win_top  = shifted >> sh_bits;
    assign pat_mask = ~64'd0 >> sh_bits;
    assign exp_hit  = win_top == (cfg.pattern & pat_mask);
    assign err_hit  = shifted[63:24] == ERR_TOKEN;

    always_comb
    begin
        window_next  = window_reg;
        count_next   = count_reg;
        zero_next    = zero_reg;
        idle_next    = idle_reg;
        outcome_next = outcome_reg;
        unique case (cmd)
            CMD_START:
            begin
                window_next  = 64'd0;
                count_next   = '0;
                zero_next    = 1'b0;
                idle_next    = 16'd0;
                outcome_next = (cfg.timeout == 16'd0) ? ST_TIMEOUT : ST_PENDING;
            end
            CMD_BYTE:
            begin
                if (timed)
                    outcome_next = ST_TIMEOUT;
                else if (outcome_reg == ST_PENDING)
                begin
                    if (stored)
                    begin
                        window_next = shifted;
                        count_next  = count_reg + 1'b1;
                        if (rx_byte == 8'd0)
                            zero_next = 1'b1;
                    end
                    if (cfg.eff_len == 4'd0)
                        outcome_next = ST_FOUND;
                    else if (stored && (rx_byte != 8'd0) && !zero_reg)
                    begin
                        if (exp_hit)
                            outcome_next = ST_FOUND;
                        else if (err_hit)
                            outcome_next = ST_ERROR;
                    end
                end
            end
            CMD_TICK:
            begin
                if (outcome_reg == ST_PENDING)
                begin
                    if (idle_reg < cfg.timeout)
                        idle_next = idle_reg + 16'd1;
                    if (idle_next >= cfg.timeout)
                        outcome_next = ST_TIMEOUT;
                end
            end
            default: ;
        endcase
    end

    assign status_next = outcome_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= 64'd0;
            count_reg   <= '0;
            zero_reg    <= 1'b0;
            idle_reg    <= 16'd0;
            outcome_reg <= ST_PENDING;
        end
        else if (step)
        begin
            window_reg  <= window_next;
            count_reg   <= count_next;
            zero_reg    <= zero_next;
            idle_reg    <= idle_next;
            outcome_reg <= outcome_next;
        end
    end

endmodule

`default_nettype wire

FILE: dv/response_token_matcher_core_tb.sv
// self-checking testbench for response_token_matcher_core: random and directed requests,
// register writes between waits, and a result scoreboard with its own matcher prediction
// depends on rtm_pkg and the response_token_matcher_core rtl
module response_token_matcher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtm_pkg::*;

    localparam cmd_t CMD_UNUSED = 2'd3;
    localparam int FILL_LIMIT = BUFFER_BYTES_DEF - 1;
    localparam logic [63:0] ERR_WORD = {24'h0, ERR_TOKEN};

    typedef struct packed {
        status_t     status;
        logic [8:0]  count;
    } wait_report_t;

    class token_match_scoreboard;
        logic [63:0] pattern;
        logic [3:0]  length;
        logic [15:0] timeout;
        logic [63:0] window;
        logic [8:0]  count;
        bit          zero_seen;
        logic [15:0] idle;
        status_t     outcome;
        wait_report_t report_q[$];
        int errors, checked, n_found, n_error, n_timeout;

        function new();
            pattern = PATTERN_RST;
            length = LENGTH_RST;
            timeout = TIMEOUT_RST;
            window = '0;
            count = '0;
            zero_seen = 1'b0;
            idle = '0;
            outcome = ST_PENDING;
        endfunction

        function void write_register(cfg_idx_t idx, logic [63:0] data);
            case (idx)
                CFG_PATTERN: pattern = data;
                CFG_LENGTH:  length = data[3:0];
                CFG_TIMEOUT: timeout = data[15:0];
                default: ;
            endcase
        endfunction

        // clamped length, cut at the first zero byte of the token
        function int token_length();
            int n;
            n = (length > PATTERN_MAX) ? PATTERN_MAX : length;
            if (n > 8) n = 8;
            for (int i = 0; i < n; i++)
                if (pattern[8*i +: 8] == 8'h00) return i;
            return n;
        endfunction

        // newest n bytes sit at the top of the window, last token byte newest
        function bit tail_equals(logic [63:0] token, int n);
            for (int i = 0; i < n; i++)
                if (window[8*(8-n+i) +: 8] != token[8*i +: 8]) return 1'b0;
            return 1'b1;
        endfunction

        function void time_check();
            if (outcome == ST_PENDING && idle >= timeout) outcome = ST_TIMEOUT;
        endfunction

        function void note_request(cmd_t cmd, logic [7:0] b);
            int n;
            bit stored, was_zero;
            wait_report_t r;
            case (cmd)
                CMD_START:
                begin
                    window = '0;
                    count = '0;
                    zero_seen = 1'b0;
                    idle = '0;
                    outcome = ST_PENDING;
                    time_check();
                end
                CMD_BYTE:
                begin
                    time_check();
                    if (outcome == ST_PENDING)
                    begin
                        stored = 1'b0;
                        was_zero = zero_seen;
                        n = token_length();
                        if (count < FILL_LIMIT)
                        begin
                            count++;
                            window = {b, window[63:8]};
                            if (b == 8'h00) zero_seen = 1'b1;
                            stored = 1'b1;
                        end
                        if (n == 0)
                            outcome = ST_FOUND;
                        else if (stored && b != 8'h00 && !was_zero)
                        begin
                            // found wins when both tokens end on this byte
                            if (tail_equals(pattern, n))
                                outcome = ST_FOUND;
                            else if (tail_equals(ERR_WORD, 5))
                                outcome = ST_ERROR;
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (outcome == ST_PENDING)
                    begin
                        if (idle < timeout) idle++;
                        time_check();
                    end
                end
                default: ;
            endcase
            r.status = outcome;
            r.count = count;
            report_q.push_back(r);
        endfunction

        function void report(string what, logic [15:0] want, logic [15:0] got);
            errors++;
            if (errors <= 10)
                $display("%0t mismatch on %s: expected %0d got %0d", $realtime, what, want, got);
        endfunction

        function void check_result(status_t st, logic [8:0] cnt);
            wait_report_t want;
            if (report_q.size() == 0)
            begin
                report("result with nothing outstanding", 16'd0, {st, 5'd0, cnt});
                return;
            end
            want = report_q.pop_front();
            checked++;
            case (want.status)
                ST_FOUND:   n_found++;
                ST_ERROR:   n_error++;
                ST_TIMEOUT: n_timeout++;
                default: ;
            endcase
            if (st !== want.status) report("status", 16'(want.status), 16'(st));
            if (cnt !== want.count) report("stored_count", 16'(want.count), 16'(cnt));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    cmd_t        command;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    status_t     status;
    logic [8:0]  stored_count;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_idx_t    cfg_index;
    logic [63:0] cfg_data;

    token_match_scoreboard sb = new();

    // driver-side copy of what was written, used to build token sequences
    logic [63:0] cur_pattern = PATTERN_RST;
    logic [3:0]  cur_length = LENGTH_RST;
    bit          quiet_sender;
    int          requests_sent;
    int          cfg_writes;

    response_token_matcher_core uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall) sb.check_result(status, stored_count);
            if (in_valid && !in_stall) sb.note_request(command, rx_byte);
        end
    end

    // mostly short holds, a few long ones
    function automatic int hold_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 94) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 9) < 7) return 8'($urandom_range(8'h21, 8'h7e));
        return 8'($urandom_range(1, 255));
    endfunction

    // every task below starts and ends just after a falling edge
    task automatic send_request(cmd_t cmd, logic [7:0] b);
        int gap;
        gap = (quiet_sender || $urandom_range(0, 1)) ? 0 : hold_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic emit_token(logic [63:0] tok, int n);
        for (int i = 0; i < n; i++) send_request(CMD_BYTE, tok[8*i +: 8]);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.report_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(cfg_idx_t idx, logic [63:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_register(idx, data);
        if (idx == CFG_PATTERN) cur_pattern = data;
        if (idx == CFG_LENGTH) cur_length = data[3:0];
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic retune();
        int r;
        logic [63:0] p;
        if ($urandom_range(0, 1))
        begin
            r = $urandom_range(0, 9);
            for (int i = 0; i < 8; i++) p[8*i +: 8] = 8'($urandom_range(8'h21, 8'h7e));
            if (r == 0) p = '1;
            else if (r == 1) p = '0;
            else if (r == 2) p[8*$urandom_range(0, 7) +: 8] = 8'h00;
            else if (r == 3) p = {$urandom, $urandom};
            write_register(CFG_PATTERN, p);
        end
        if ($urandom_range(0, 1))
        begin
            r = $urandom_range(0, 9);
            if (r == 0) p = 64'd0;
            else if (r == 1) p = 64'($urandom_range(9, 15));
            else if (r == 2) p = 64'd8;
            else if (r == 3) p = 64'd1;
            else p = 64'($urandom_range(1, 8));
            write_register(CFG_LENGTH, p);
        end
        if ($urandom_range(0, 1))
        begin
            r = $urandom_range(0, 19);
            if (r == 0) p = 64'd0;
            else if (r < 3) p = 64'hffff;
            else if (r < 11) p = 64'($urandom_range(1, 12));
            else p = 64'($urandom_range(13, 3000));
            write_register(CFG_TIMEOUT, p);
        end
    endtask

    // one wait: start, then noise, whole or partial tokens, ticks and restarts
    task automatic run_wait();
        int steps, r, n;
        quiet_sender = ($urandom_range(0, 3) == 0);
        n = (cur_length > 8) ? 8 : cur_length;
        send_request(CMD_START, 8'($urandom));
        steps = $urandom_range(1, 24);
        repeat (steps)
        begin
            r = $urandom_range(0, 99);
            if (r < 38) send_request(CMD_BYTE, noise_byte());
            else if (r < 55) emit_token(cur_pattern, n);
            else if (r < 61) emit_token(cur_pattern, $urandom_range(0, n));
            else if (r < 70) emit_token(ERR_WORD, 5);
            else if (r < 86) repeat ($urandom_range(1, 4)) send_request(CMD_TICK, 8'($urandom));
            else if (r < 90) send_request(CMD_UNUSED, 8'($urandom));
            else if (r < 93) send_request(CMD_START, 8'($urandom));
            else if (r < 97) send_request(CMD_BYTE, 8'h00);
            else wait_idle();
        end
    endtask

    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20)) @(negedge clk);
            out_stall <= 1'b1;
            repeat (hold_len()) @(negedge clk);
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_START;
        rx_byte = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = CFG_PATTERN;
        cfg_data = '0;
        quiet_sender = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default token, sticky outcome, unused command
        send_request(CMD_START, 8'h00);
        emit_token(PATTERN_RST, 2);
        send_request(CMD_BYTE, 8'hff);
        send_request(CMD_TICK, 8'h00);
        send_request(CMD_UNUSED, 8'hff);
        // error token
        send_request(CMD_START, 8'h00);
        emit_token(ERR_WORD, 5);
        // zero byte stops matching
        send_request(CMD_START, 8'h00);
        send_request(CMD_BYTE, 8'h00);
        emit_token(PATTERN_RST, 2);
        send_request(CMD_TICK, 8'h00);
        // both tokens end on the same byte
        write_register(CFG_PATTERN, 64'h0000_0000_0052_4f52);
        write_register(CFG_LENGTH, 64'd3);
        send_request(CMD_START, 8'h00);
        emit_token(ERR_WORD, 5);
        // zero timeout expires on start, and a byte after it is not stored
        write_register(CFG_PATTERN, '1);
        write_register(CFG_LENGTH, 64'd15);
        write_register(CFG_TIMEOUT, 64'd0);
        send_request(CMD_START, 8'h00);
        send_request(CMD_BYTE, 8'hff);

        // fill the buffer past its limit with bytes that cannot match
        write_register(CFG_TIMEOUT, 64'hffff);
        write_register(CFG_PATTERN, {$urandom_range(65, 90), $urandom_range(65, 90)});
        write_register(CFG_LENGTH, 64'd8);
        send_request(CMD_START, 8'h00);
        repeat ($urandom_range(512, 530)) send_request(CMD_BYTE, 8'($urandom_range(8'h61, 8'h7a)));
        send_request(CMD_TICK, 8'h00);

        while (requests_sent < 700)
        begin
            if ($urandom_range(0, 5) == 0) retune();
            run_wait();
        end
        wait_idle();

        $display("covered %0d requests and %0d register writes, %0d results compared",
                 requests_sent, cfg_writes, sb.checked);
        $display("expected outcomes: %0d found, %0d error, %0d timeout; %0d mismatches",
                 sb.n_found, sb.n_error, sb.n_timeout, sb.errors);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d results outstanding", sb.report_q.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
